@@ hdl/rg32_pkg.sv @@
// Shared types and constants for the RadioGatun[32] hash and stream generator.
`timescale 1ns / 1ps

package rg32_pkg;

  localparam int MILL_LEN  = 19;
  localparam int BELT_ROW  = 13;
  localparam int BELT_ROWS = 3;
  localparam int BELT_LEN  = BELT_ROW * BELT_ROWS;

  // Rounds that follow the padded group on finish.
  localparam int FINISH_ROUNDS = 17;

  typedef logic [31:0]                 word_t;
  typedef logic [MILL_LEN-1:0][31:0]   mill_t;
  typedef logic [BELT_LEN-1:0][31:0]   belt_t;
  typedef logic [BELT_ROWS-1:0][31:0]  group_t;
  typedef logic [4:0]                  rounds_t;
  typedef logic [1:0]                  action_t;

  localparam action_t ACT_ABSORB  = 2'd0;
  localparam action_t ACT_FINISH  = 2'd1;
  localparam action_t ACT_SQUEEZE = 2'd2;
  localparam action_t ACT_RESTART = 2'd3;

  function automatic word_t rot_right(input word_t x, input int r);
    word_t res;
    res = (x >> r) | (x << (32 - r));
    if (r == 0) begin
      res = x;
    end
    return res;
  endfunction

  function automatic word_t byte_swap(input word_t w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

@@ hdl/rg32_round.sv @@
// One belt-and-mill round of RadioGatun[32], purely combinational.
`timescale 1ns / 1ps

module rg32_round (
  input  rg32_pkg::mill_t mill_in,
  input  rg32_pkg::belt_t belt_in,
  output rg32_pkg::mill_t mill_out,
  output rg32_pkg::belt_t belt_out
);

  import rg32_pkg::*;

  mill_t  t;
  mill_t  gamma;
  group_t last;

  always_comb begin
    int y;
    int r;
    // Belt rotation: every row moves one place, its last word wrapping to the front.
    for (int s = 0; s < BELT_ROWS; s++) begin
      last[s] = belt_in[s*BELT_ROW + BELT_ROW - 1];
      belt_out[s*BELT_ROW] = last[s];
      for (int j = 1; j < BELT_ROW; j++) begin
        belt_out[s*BELT_ROW + j] = belt_in[s*BELT_ROW + j - 1];
      end
    end
    // Mill-to-belt feed forward from the old mill.
    for (int i = 0; i < 12; i++) begin
      belt_out[(i + 1) + (i % 3) * BELT_ROW] =
        belt_out[(i + 1) + (i % 3) * BELT_ROW] ^ mill_in[i + 1];
    end
    // Nonlinear step with permutation and rotation.
    for (int i = 0; i < MILL_LEN; i++) begin
      y = (i * 7) % MILL_LEN;
      r = ((i * (i + 1)) / 2) % 32;
      gamma[i] = mill_in[y] ^
                 (mill_in[(y + 1) % MILL_LEN] | ~mill_in[(y + 2) % MILL_LEN]);
      t[i] = rot_right(gamma[i], r);
    end
    // Diffusion, asymmetry constant and belt-to-mill feed forward.
    for (int i = 0; i < MILL_LEN; i++) begin
      mill_out[i] = t[i] ^ t[(i + 1) % MILL_LEN] ^ t[(i + 4) % MILL_LEN];
    end
    mill_out[0] = mill_out[0] ^ 32'h0000_0001;
    for (int i = 0; i < BELT_ROWS; i++) begin
      mill_out[13 + i] = mill_out[13 + i] ^ last[i];
    end
  end

endmodule

@@ hdl/radiogatun32_hash_prng.sv @@
// RadioGatun[32] hash and pseudo-random stream generator: top level with its sequencer.
// Absorb and restart update the state directly; an absorb that completes a group injects it, then runs its round.
// Finish injects the padded group, then runs 17 rounds of the shared unit.
// Squeeze registers its word from the mill, or does so after the round that is due first.
// No new item is taken while rounds run; the single round unit sets the pace.
// Reset (rst, synchronous, active high) clears belt, mill and all counters, as restart does.
`timescale 1ns / 1ps

module radiogatun32_hash_prng (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // in_byte [7:0]
  input  rg32_pkg::action_t    s_tuser,   // action [1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output rg32_pkg::word_t      m_tdata    // out_word [31:0]
);

  import rg32_pkg::*;

  // The sequencer is either waiting for a transfer or driving the round unit.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic    state;
  rounds_t rounds_left;
  logic    squeeze_pend;

  mill_t   mill;
  belt_t   belt;
  word_t   partial;
  group_t  group;
  logic [1:0] byte_place;
  logic [1:0] word_place;
  logic [1:0] out_place;
  logic    finished;

  mill_t   round_mill;
  belt_t   round_belt;

  logic    accept;
  logic    give_now;
  word_t   new_word;
  logic [7:0] byte_sel;
  group_t  inj_group;
  mill_t   inj_mill;
  belt_t   inj_belt;

  // The single shared round unit; every round of every action passes through it.
  rg32_round u_round (
    .mill_in  (mill),
    .belt_in  (belt),
    .mill_out (round_mill),
    .belt_out (round_belt)
  );

  // A new item is taken only when the sequencer is idle and the output register
  // is empty or being emptied in this cycle.
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // A squeeze whose word is ready loads the output register in the same cycle,
  // so the register is not emptied then.
  assign give_now = accept && (s_tuser == ACT_SQUEEZE) &&
                    (out_place == 2'd1 || out_place == 2'd2);

  // The word being packed with the incoming byte, or with the padding byte on
  // finish, placed at the current byte position.
  always_comb begin
    byte_sel = (s_tuser == ACT_FINISH) ? 8'h01 : s_tdata;
    new_word = partial | ({24'b0, byte_sel} << {byte_place, 3'b000});
    for (int c = 0; c < BELT_ROWS; c++) begin
      inj_group[c] = (word_place == 2'(c)) ? new_word : group[c];
    end
    inj_mill = mill;
    inj_belt = belt;
    for (int c = 0; c < BELT_ROWS; c++) begin
      inj_belt[c*BELT_ROW]  = belt[c*BELT_ROW] ^ inj_group[c];
      inj_mill[16 + c]      = mill[16 + c] ^ inj_group[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rounds_left  <= '0;
      squeeze_pend <= 1'b0;
      mill         <= '0;
      belt         <= '0;
      partial      <= '0;
      group        <= '0;
      byte_place   <= '0;
      word_place   <= '0;
      out_place    <= '0;
      finished     <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (m_tvalid && m_tready && !give_now) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              ACT_ABSORB: begin
                if (!finished) begin
                  if (byte_place == 2'd3) begin
                    partial    <= '0;
                    byte_place <= '0;
                    if (word_place == 2'd2) begin
                      // Group complete: inject now, its round follows.
                      mill        <= inj_mill;
                      belt        <= inj_belt;
                      group       <= '0;
                      word_place  <= '0;
                      rounds_left <= rounds_t'(1);
                      state       <= ST_RUN;
                    end else begin
                      group[word_place] <= new_word;
                      word_place        <= word_place + 2'd1;
                    end
                  end else begin
                    partial    <= new_word;
                    byte_place <= byte_place + 2'd1;
                  end
                end
              end
              ACT_FINISH: begin
                if (!finished) begin
                  // Whatever the fill, the padded group is injected and 17 rounds
                  // follow (a group completed by the padding counts its own round).
                  mill        <= inj_mill;
                  belt        <= inj_belt;
                  group       <= '0;
                  partial     <= '0;
                  byte_place  <= '0;
                  word_place  <= '0;
                  finished    <= 1'b1;
                  rounds_left <= rounds_t'(FINISH_ROUNDS);
                  state       <= ST_RUN;
                end
              end
              ACT_SQUEEZE: begin
                if (out_place == 2'd1 || out_place == 2'd2) begin
                  m_tdata   <= byte_swap((out_place == 2'd1) ? mill[1] : mill[2]);
                  m_tvalid  <= 1'b1;
                  out_place <= out_place + 2'd1;
                end else begin
                  squeeze_pend <= 1'b1;
                  rounds_left  <= rounds_t'(1);
                  state        <= ST_RUN;
                end
              end
              ACT_RESTART: begin
                mill       <= '0;
                belt       <= '0;
                partial    <= '0;
                group      <= '0;
                byte_place <= '0;
                word_place <= '0;
                out_place  <= '0;
                finished   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          mill        <= round_mill;
          belt        <= round_belt;
          rounds_left <= rounds_left - rounds_t'(1);
          if (rounds_left == rounds_t'(1)) begin
            state <= ST_IDLE;
            if (squeeze_pend) begin
              // The round that was due has run: give mill word 1 straight away.
              m_tdata      <= byte_swap(round_mill[1]);
              m_tvalid     <= 1'b1;
              out_place    <= 2'd2;
              squeeze_pend <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
